FILE: hdl/ctc_pkg.sv
package ctc_pkg;

  localparam int unsigned PIX_W       = 8;
  localparam int unsigned COORD_W     = 10;
  localparam int unsigned W_SUM_W     = 28;
  localparam int unsigned XY_SUM_W    = 38;
  localparam int unsigned QUOT_STEPS  = COORD_W;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned REG_ADDR_W  = 5;
  localparam int unsigned APB_DATA_W  = 32;

  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 1024;

  // register indexes, byte address is 4 * index
  localparam logic [2:0] REG_RED_MIN   = 3'd0;
  localparam logic [2:0] REG_RED_MAX   = 3'd1;
  localparam logic [2:0] REG_GREEN_MIN = 3'd2;
  localparam logic [2:0] REG_GREEN_MAX = 3'd3;
  localparam logic [2:0] REG_BLUE_MIN  = 3'd4;
  localparam logic [2:0] REG_BLUE_MAX  = 3'd5;

  localparam logic [PIX_W-1:0] RST_RED_MIN   = 8'd150;
  localparam logic [PIX_W-1:0] RST_RED_MAX   = 8'd255;
  localparam logic [PIX_W-1:0] RST_GREEN_MIN = 8'd0;
  localparam logic [PIX_W-1:0] RST_GREEN_MAX = 8'd50;
  localparam logic [PIX_W-1:0] RST_BLUE_MIN  = 8'd0;
  localparam logic [PIX_W-1:0] RST_BLUE_MAX  = 8'd50;

  typedef struct packed {
    logic [PIX_W-1:0] red_min;
    logic [PIX_W-1:0] red_max;
    logic [PIX_W-1:0] green_min;
    logic [PIX_W-1:0] green_max;
    logic [PIX_W-1:0] blue_min;
    logic [PIX_W-1:0] blue_max;
  } thresh_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_CHECK,
    BS_DIV
  } back_state_e;

endpackage

FILE: hdl/color_threshold_centroid_unit.sv
// RGB color threshold with red-weighted centroid. Pixels arrive in raster order on the
// slave stream (tlast ends a row, tuser ends the frame); the block counts column and row
// itself, blacks out any pixel whose red, green or blue lies outside its inclusive
// min/max window, and sends one result per pixel on the master stream. On the frame's
// last pixel the result also carries the centroid sum(x*w)/sum(w), sum(y*w)/sum(w) with
// w the masked red value (truncated, saturated at 1023), or frame_empty when no weight
// was seen; the sums and counters then clear. Between frame ends, and while the master
// stream is ready, the block sustains one pixel per clock. A frame-end pixel holds the
// back end while it takes the totals, does one range check and runs ten quotient steps
// of the shared restoring divider; the four-entry queue between front and back takes the
// next four pixels meanwhile, after which the input stalls until the divider is done,
// and further pixels are taken at full rate again once its result is out. The
// thresholds sit on an APB port, one 8-bit register per word at addresses 0x00 to 0x14
// (red_min, red_max, green_min, green_max, blue_min, blue_max); write them only while
// the stream is idle.
module color_threshold_centroid_unit #(
  parameter int unsigned MAX_WIDTH  = ctc_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = ctc_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ctc_pkg::REG_ADDR_W-1:0]      paddr,
  input  logic [ctc_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [ctc_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready,
  // pixel input
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [23:0]                         s_axis_tdata,  // red, green, blue
  input  logic                                s_axis_tlast,  // end_of_line
  input  logic                                s_axis_tuser,  // end_of_frame
  // result output
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [47:0]                         m_axis_tdata,  // out_red, out_green, out_blue,
                                                             // centroid_x, centroid_y, 4'b0
  output logic                                m_axis_tlast,  // centroid_valid
  output logic                                m_axis_tuser   // frame_empty
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned EW = 3 * ctc_pkg::PIX_W + 1 + CW + RW + 2 * ctc_pkg::PIX_W;

  ctc_pkg::thresh_t thresh;

  logic          push, full, q_valid, pop;
  logic [EW-1:0] entry_in, entry_out;
  logic [3*ctc_pkg::PIX_W-1:0] rgb;
  logic [ctc_pkg::COORD_W-1:0] cx, cy;

  ctc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .thresh_o(thresh)
  );

  // front: mask the pixel, track position, form the weighted products
  ctc_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .thresh_i(thresh),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .red_i   (s_axis_tdata[7:0]),
    .green_i (s_axis_tdata[15:8]),
    .blue_i  (s_axis_tdata[23:16]),
    .eol_i   (s_axis_tlast),
    .eof_i   (s_axis_tuser),
    .push_o  (push),
    .full_i  (full),
    .entry_o (entry_in)
  );

  // hold classified pixels while the back end divides at frame end
  ctc_fifo #(
    .WIDTH(EW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (entry_in),
    .full_o (full),
    .valid_o(q_valid),
    .pop_i  (pop),
    .data_o (entry_out)
  );

  // back: accumulate, divide at frame end, drive the output register
  ctc_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(q_valid),
    .pop_o  (pop),
    .entry_i(entry_out),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .rgb_o  (rgb),
    .last_o (m_axis_tlast),
    .cx_o   (cx),
    .cy_o   (cy),
    .empty_o(m_axis_tuser)
  );

  assign m_axis_tdata = {4'b0000, cy, cx, rgb};

endmodule

FILE: hdl/ctc_regs.sv
module ctc_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ctc_pkg::REG_ADDR_W-1:0]      paddr,
  input  logic [ctc_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [ctc_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready,
  output ctc_pkg::thresh_t                    thresh_o
);

  ctc_pkg::thresh_t thr_q, thr_d;
  logic [2:0] idx;
  logic [ctc_pkg::PIX_W-1:0] wval;
  logic [ctc_pkg::PIX_W-1:0] rval;

  assign idx    = paddr[4:2];
  assign wval   = pwdata[ctc_pkg::PIX_W-1:0];
  assign pready = 1'b1;

  always_comb begin
    thr_d = thr_q;
    if (psel && penable && pwrite) begin
      unique case (idx)
        ctc_pkg::REG_RED_MIN:   thr_d.red_min   = wval;
        ctc_pkg::REG_RED_MAX:   thr_d.red_max   = wval;
        ctc_pkg::REG_GREEN_MIN: thr_d.green_min = wval;
        ctc_pkg::REG_GREEN_MAX: thr_d.green_max = wval;
        ctc_pkg::REG_BLUE_MIN:  thr_d.blue_min  = wval;
        ctc_pkg::REG_BLUE_MAX:  thr_d.blue_max  = wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ctc_pkg::REG_RED_MIN:   rval = thr_q.red_min;
      ctc_pkg::REG_RED_MAX:   rval = thr_q.red_max;
      ctc_pkg::REG_GREEN_MIN: rval = thr_q.green_min;
      ctc_pkg::REG_GREEN_MAX: rval = thr_q.green_max;
      ctc_pkg::REG_BLUE_MIN:  rval = thr_q.blue_min;
      ctc_pkg::REG_BLUE_MAX:  rval = thr_q.blue_max;
      default:                rval = '0;
    endcase
  end

  assign prdata = {{(ctc_pkg::APB_DATA_W-ctc_pkg::PIX_W){1'b0}}, rval};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q.red_min   <= ctc_pkg::RST_RED_MIN;
      thr_q.red_max   <= ctc_pkg::RST_RED_MAX;
      thr_q.green_min <= ctc_pkg::RST_GREEN_MIN;
      thr_q.green_max <= ctc_pkg::RST_GREEN_MAX;
      thr_q.blue_min  <= ctc_pkg::RST_BLUE_MIN;
      thr_q.blue_max  <= ctc_pkg::RST_BLUE_MAX;
    end else begin
      thr_q <= thr_d;
    end
  end

  assign thresh_o = thr_q;

endmodule

FILE: hdl/ctc_front.sv
module ctc_front #(
  parameter int unsigned MAX_WIDTH  = ctc_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = ctc_pkg::DEF_MAX_HEIGHT,
  localparam int unsigned CW = $clog2(MAX_WIDTH),
  localparam int unsigned RW = $clog2(MAX_HEIGHT),
  localparam int unsigned PX = CW + ctc_pkg::PIX_W,
  localparam int unsigned PY = RW + ctc_pkg::PIX_W,
  localparam int unsigned EW = 3 * ctc_pkg::PIX_W + 1 + PX + PY
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ctc_pkg::thresh_t              thresh_i,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [ctc_pkg::PIX_W-1:0]     red_i,
  input  logic [ctc_pkg::PIX_W-1:0]     green_i,
  input  logic [ctc_pkg::PIX_W-1:0]     blue_i,
  input  logic                          eol_i,
  input  logic                          eof_i,
  output logic                          push_o,
  input  logic                          full_i,
  output logic [EW-1:0]                 entry_o
);

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic pass;
  logic [ctc_pkg::PIX_W-1:0] mr, mg, mb;
  logic [PX-1:0] xp;
  logic [PY-1:0] yp;

  assign ready_o = !full_i;
  assign push_o  = valid_i && !full_i;

  assign pass = (thresh_i.red_min <= red_i) && (red_i <= thresh_i.red_max)
             && (thresh_i.green_min <= green_i) && (green_i <= thresh_i.green_max)
             && (thresh_i.blue_min <= blue_i) && (blue_i <= thresh_i.blue_max);

  assign mr = pass ? red_i   : '0;
  assign mg = pass ? green_i : '0;
  assign mb = pass ? blue_i  : '0;

  // position weights, one product per axis
  assign xp = PX'(col_q) * PX'(mr);
  assign yp = PY'(row_q) * PY'(mr);

  assign entry_o = {yp, xp, eof_i, mb, mg, mr};

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (push_o) begin
      if (eof_i) begin
        col_d = '0;
        row_d = '0;
      end else if (eol_i) begin
        col_d = '0;
        if (row_q < RW'(MAX_HEIGHT - 1)) begin
          row_d = row_q + 1'b1;
        end
      end else if (col_q < CW'(MAX_WIDTH - 1)) begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

FILE: hdl/ctc_fifo.sv
module ctc_fifo #(
  parameter int unsigned WIDTH = 8,
  localparam int unsigned DEPTH = ctc_pkg::QUEUE_DEPTH,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/ctc_back.sv
module ctc_back #(
  parameter int unsigned MAX_WIDTH  = ctc_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = ctc_pkg::DEF_MAX_HEIGHT,
  localparam int unsigned CW = $clog2(MAX_WIDTH),
  localparam int unsigned RW = $clog2(MAX_HEIGHT),
  localparam int unsigned PX = CW + ctc_pkg::PIX_W,
  localparam int unsigned PY = RW + ctc_pkg::PIX_W,
  localparam int unsigned EW = 3 * ctc_pkg::PIX_W + 1 + PX + PY
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            pop_o,
  input  logic [EW-1:0]                   entry_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output logic [3*ctc_pkg::PIX_W-1:0]     rgb_o,
  output logic                            last_o,
  output logic [ctc_pkg::COORD_W-1:0]     cx_o,
  output logic [ctc_pkg::COORD_W-1:0]     cy_o,
  output logic                            empty_o
);

  localparam int unsigned WS = ctc_pkg::W_SUM_W;
  localparam int unsigned XS = ctc_pkg::XY_SUM_W;
  localparam int unsigned QW = ctc_pkg::COORD_W;
  localparam int unsigned SW = $clog2(ctc_pkg::QUOT_STEPS);
  localparam int unsigned DW = WS + QW - 1;

  ctc_pkg::back_state_e state_q, state_d;

  logic [WS-1:0] w_q, w_d;
  logic [XS-1:0] x_q, x_d, y_q, y_d;
  logic [WS-1:0] den_q, den_d;
  logic [XS-1:0] xr_q, xr_d, yr_q, yr_d;
  logic [DW-1:0] dsh_q, dsh_d;
  logic [QW-1:0] qx_q, qx_d, qy_q, qy_d;
  logic          xsat_q, xsat_d, ysat_q, ysat_d;
  logic [SW-1:0] step_q, step_d;

  logic                        out_valid_q, out_valid_d;
  logic [3*ctc_pkg::PIX_W-1:0] rgb_q, rgb_d;
  logic                        last_q, last_d;
  logic [QW-1:0]               cx_q, cx_d, cy_q, cy_d;
  logic                        empty_q, empty_d;

  logic [ctc_pkg::PIX_W-1:0] e_red;
  logic                      e_eof;
  logic [PX-1:0]             e_xp;
  logic [PY-1:0]             e_yp;
  logic [WS:0]               w_sum;
  logic [XS:0]               x_sum, y_sum;
  logic [WS-1:0]             w_new;
  logic [XS-1:0]             x_new, y_new;
  logic                      can_load;
  logic                      x_ge, y_ge;
  logic [QW-1:0]             qx_nx, qy_nx;

  assign e_red = entry_i[ctc_pkg::PIX_W-1:0];
  assign e_eof = entry_i[3*ctc_pkg::PIX_W];
  assign e_xp  = entry_i[3*ctc_pkg::PIX_W+1 +: PX];
  assign e_yp  = entry_i[3*ctc_pkg::PIX_W+1+PX +: PY];

  // saturating accumulation: sums never exceed their maximum, so a carry means overflow
  assign w_sum = {1'b0, w_q} + (WS+1)'(e_red);
  assign x_sum = {1'b0, x_q} + (XS+1)'(e_xp);
  assign y_sum = {1'b0, y_q} + (XS+1)'(e_yp);
  assign w_new = w_sum[WS] ? '1 : w_sum[WS-1:0];
  assign x_new = x_sum[XS] ? '1 : x_sum[XS-1:0];
  assign y_new = y_sum[XS] ? '1 : y_sum[XS-1:0];

  assign can_load = !out_valid_q || ready_i;

  assign x_ge  = (xr_q >= XS'(dsh_q));
  assign y_ge  = (yr_q >= XS'(dsh_q));
  assign qx_nx = {qx_q[QW-2:0], x_ge};
  assign qy_nx = {qy_q[QW-2:0], y_ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ctc_pkg::BS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    pop_o       = 1'b0;
    w_d         = w_q;
    x_d         = x_q;
    y_d         = y_q;
    den_d       = den_q;
    xr_d        = xr_q;
    yr_d        = yr_q;
    dsh_d       = dsh_q;
    qx_d        = qx_q;
    qy_d        = qy_q;
    xsat_d      = xsat_q;
    ysat_d      = ysat_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && !ready_i;
    rgb_d       = rgb_q;
    last_d      = last_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    empty_d     = empty_q;
    unique case (state_q)
      ctc_pkg::BS_IDLE: begin
        if (valid_i && can_load) begin
          pop_o  = 1'b1;
          rgb_d  = entry_i[3*ctc_pkg::PIX_W-1:0];
          last_d = e_eof;
          cx_d   = '0;
          cy_d   = '0;
          empty_d = 1'b0;
          if (e_eof) begin
            // hand the frame totals to the divider and clear for the next frame
            den_d   = w_new;
            xr_d    = x_new;
            yr_d    = y_new;
            w_d     = '0;
            x_d     = '0;
            y_d     = '0;
            state_d = ctc_pkg::BS_CHECK;
          end else begin
            w_d         = w_new;
            x_d         = x_new;
            y_d         = y_new;
            out_valid_d = 1'b1;
          end
        end
      end
      ctc_pkg::BS_CHECK: begin
        if (den_q == '0) begin
          empty_d     = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ctc_pkg::BS_IDLE;
        end else begin
          // quotient above the coordinate range saturates
          xsat_d  = (xr_q >= {den_q, {QW{1'b0}}});
          ysat_d  = (yr_q >= {den_q, {QW{1'b0}}});
          dsh_d   = {den_q, {(QW-1){1'b0}}};
          qx_d    = '0;
          qy_d    = '0;
          step_d  = SW'(ctc_pkg::QUOT_STEPS - 1);
          state_d = ctc_pkg::BS_DIV;
        end
      end
      ctc_pkg::BS_DIV: begin
        if (x_ge) xr_d = xr_q - XS'(dsh_q);
        if (y_ge) yr_d = yr_q - XS'(dsh_q);
        qx_d  = qx_nx;
        qy_d  = qy_nx;
        dsh_d = dsh_q >> 1;
        step_d = step_q - 1'b1;
        if (step_q == '0) begin
          cx_d        = xsat_q ? '1 : qx_nx;
          cy_d        = ysat_q ? '1 : qy_nx;
          out_valid_d = 1'b1;
          state_d     = ctc_pkg::BS_IDLE;
        end
      end
      default: state_d = ctc_pkg::BS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q         <= '0;
      x_q         <= '0;
      y_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      w_q         <= w_d;
      x_q         <= x_d;
      y_q         <= y_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q   <= den_d;
    xr_q    <= xr_d;
    yr_q    <= yr_d;
    dsh_q   <= dsh_d;
    qx_q    <= qx_d;
    qy_q    <= qy_d;
    xsat_q  <= xsat_d;
    ysat_q  <= ysat_d;
    step_q  <= step_d;
    rgb_q   <= rgb_d;
    last_q  <= last_d;
    cx_q    <= cx_d;
    cy_q    <= cy_d;
    empty_q <= empty_d;
  end

  assign valid_o = out_valid_q;
  assign rgb_o   = rgb_q;
  assign last_o  = last_q;
  assign cx_o    = cx_q;
  assign cy_o    = cy_q;
  assign empty_o = empty_q;

endmodule
